[design/mdp_pkg.sv]
package mdp_pkg;

  // Field widths of the pixel stream.
  localparam int COORD_BITS = 12;
  localparam int DEPTH_BITS = 24;

  // Register widths.
  localparam int CENTER_W  = 16;
  localparam int INVF_W    = 24;
  localparam int HALF_W    = INVF_W / 2;
  localparam int CFG_W     = (DEPTH_BITS > INVF_W) ? DEPTH_BITS : INVF_W;
  localparam int CFG_IDX_W = 3;

  // Datapath widths.
  localparam int PIX_W   = COORD_BITS + 4;
  localparam int MAG_W   = (PIX_W > CENTER_W) ? PIX_W : CENTER_W;
  localparam int DIFF_W  = MAG_W + 1;
  localparam int PROD_W  = MAG_W + DEPTH_BITS;
  localparam int PART_W  = PROD_W + HALF_W;
  localparam int TOTAL_W = PROD_W + INVF_W;

  // Output format: Q.44 product shifted down to Q.16, 26-bit signed result.
  localparam int FRAC_SHIFT = 28;
  localparam int XY_W       = 26;
  localparam logic [XY_W-1:0] XY_MAX = {1'b0, {(XY_W-1){1'b1}}};
  localparam logic [XY_W-1:0] XY_MIN = {1'b1, {(XY_W-1){1'b0}}};

  // Stages of the projection unit after the front stage.
  localparam int AXIS_STAGES = 4;

  // Reset values of the registers.
  localparam logic [CENTER_W-1:0]   PRINCIPAL_X_RST = CENTER_W'(5120);
  localparam logic [CENTER_W-1:0]   PRINCIPAL_Y_RST = CENTER_W'(3840);
  localparam logic [INVF_W-1:0]     INV_FOCAL_X_RST = INVF_W'(31957);
  localparam logic [INVF_W-1:0]     INV_FOCAL_Y_RST = INVF_W'(31957);
  localparam logic [DEPTH_BITS-1:0] MAX_RANGE_RST   = DEPTH_BITS'(655360);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRINCIPAL_X = 3'd0,
    REG_PRINCIPAL_Y = 3'd1,
    REG_INV_FOCAL_X = 3'd2,
    REG_INV_FOCAL_Y = 3'd3,
    REG_MAX_RANGE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CENTER_W-1:0]   principal_x;
    logic [CENTER_W-1:0]   principal_y;
    logic [INVF_W-1:0]     inv_focal_x;
    logic [INVF_W-1:0]     inv_focal_y;
    logic [DEPTH_BITS-1:0] max_range;
  } cfg_t;

  // Per-pixel data leaving the front stage.
  typedef struct packed {
    logic                  valid;
    logic                  frame_end;
    logic [DEPTH_BITS-1:0] depth;
  } front_t;

  // Offset from the principal point as sign and magnitude.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } axis_in_t;

endpackage

[design/mdp_cfg_regs.sv]
module mdp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mdp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mdp_pkg::CFG_W-1:0]     cfg_data,
  output mdp_pkg::cfg_t                 cfg
);
  import mdp_pkg::*;

  // Register file, written one register per transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.principal_x <= PRINCIPAL_X_RST;
      cfg.principal_y <= PRINCIPAL_Y_RST;
      cfg.inv_focal_x <= INV_FOCAL_X_RST;
      cfg.inv_focal_y <= INV_FOCAL_Y_RST;
      cfg.max_range   <= MAX_RANGE_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRINCIPAL_X: cfg.principal_x <= cfg_data[CENTER_W-1:0];
        REG_PRINCIPAL_Y: cfg.principal_y <= cfg_data[CENTER_W-1:0];
        REG_INV_FOCAL_X: cfg.inv_focal_x <= cfg_data[INVF_W-1:0];
        REG_INV_FOCAL_Y: cfg.inv_focal_y <= cfg_data[INVF_W-1:0];
        REG_MAX_RANGE:   cfg.max_range   <= cfg_data[DEPTH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[design/mdp_front.sv]
module mdp_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [mdp_pkg::DEPTH_BITS-1:0] depth_sample,
  input  logic                           depth_not_finite,
  input  logic [7:0]                     mask_byte,
  input  logic [mdp_pkg::COORD_BITS-1:0] column,
  input  logic [mdp_pkg::COORD_BITS-1:0] row,
  input  logic                           frame_end_in,
  input  mdp_pkg::cfg_t                  cfg,
  output mdp_pkg::front_t                front,
  output mdp_pkg::axis_in_t              x_in,
  output mdp_pkg::axis_in_t              y_in
);
  import mdp_pkg::*;

  logic [DEPTH_BITS-1:0] depth_eff;
  axis_in_t              x_off;
  axis_in_t              y_off;

  // Pixel position in Q.4 minus the principal point, as sign and magnitude.
  function automatic axis_in_t offset(input logic [COORD_BITS-1:0] pix,
                                      input logic [CENTER_W-1:0]   center);
    logic [DIFF_W-1:0] diff;
    axis_in_t          res;
    diff    = DIFF_W'({pix, 4'b0000}) - DIFF_W'(center);
    res.neg = diff[DIFF_W-1];
    res.mag = res.neg ? MAG_W'(-diff) : diff[MAG_W-1:0];
    return res;
  endfunction

  // A masked pixel has zero depth; otherwise invalid or far depths clamp.
  always_comb begin
    if (mask_byte == 8'd0) begin
      depth_eff = '0;
    end else if (depth_not_finite || (depth_sample > cfg.max_range)) begin
      depth_eff = cfg.max_range;
    end else begin
      depth_eff = depth_sample;
    end
    x_off = offset(column, cfg.principal_x);
    y_off = offset(row, cfg.principal_y);
  end

  // Front stage registers; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else begin
      front.valid <= accept;
    end
    front.frame_end <= frame_end_in;
    front.depth     <= depth_eff;
    x_in            <= x_off;
    y_in            <= y_off;
  end

endmodule

[design/mdp_axis.sv]
module mdp_axis (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  mdp_pkg::axis_in_t              ain,
  input  logic [mdp_pkg::DEPTH_BITS-1:0] depth,
  input  logic [mdp_pkg::INVF_W-1:0]     inv_focal,
  output logic                           out_valid,
  output logic [mdp_pkg::XY_W-1:0]       coord
);
  import mdp_pkg::*;

  localparam logic [TOTAL_W:0] ROUND_ADD = (TOTAL_W+1)'(1) << (FRAC_SHIFT - 1);
  localparam int SAT_LSB = FRAC_SHIFT + XY_W - 1;

  // Stage valid bits.
  logic v2, v3, v4;

  // Stage 2: offset times depth.
  logic              neg2;
  logic [PROD_W-1:0] prod2;
  // Stage 3: partial products with the two halves of the reciprocal.
  logic              neg3;
  logic [PART_W-1:0] part_hi3;
  logic [PART_W-1:0] part_lo3;
  // Stage 4: rounded magnitude and overflow flag.
  logic              neg4;
  logic              sat4;
  logic [XY_W-2:0]   mag4;

  logic [TOTAL_W:0]  rounded;
  logic [XY_W-1:0]   coord_next;

  // Sum of partial products with half an LSB of the Q.16 result added.
  always_comb begin
    rounded = ((TOTAL_W+1)'(part_hi3) << HALF_W) + (TOTAL_W+1)'(part_lo3) + ROUND_ADD;
  end

  // Saturate and apply the sign.
  always_comb begin
    if (sat4) begin
      coord_next = neg4 ? XY_MIN : XY_MAX;
    end else if (neg4) begin
      coord_next = -{1'b0, mag4};
    end else begin
      coord_next = {1'b0, mag4};
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v2        <= in_valid;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    neg2     <= ain.neg;
    prod2    <= PROD_W'(ain.mag) * PROD_W'(depth);
    neg3     <= neg2;
    part_hi3 <= PART_W'(prod2) * PART_W'(inv_focal[INVF_W-1:HALF_W]);
    part_lo3 <= PART_W'(prod2) * PART_W'(inv_focal[HALF_W-1:0]);
    neg4     <= neg3;
    sat4     <= |rounded[TOTAL_W:SAT_LSB];
    mag4     <= rounded[SAT_LSB-1:FRAC_SHIFT];
    coord    <= coord_next;
  end

endmodule

[design/masked_depth_to_point_projector_top.sv]
// Channel   Signals                                                  Transfer when
// ------    -------------------------------------------------------  -----------------
// pixel     depth_sample depth_not_finite mask_byte column row        start && !busy
//           frame_end_in
// point     point_x point_y point_z frame_end_out                     done (one cycle)
// config    cfg_index cfg_data                                        cfg_write
//
// One pixel is taken every clock that start is high; busy is high only during reset.
// A point transfers behind a front stage, a depth multiply, the reciprocal partial
// products, the rounding add and an output register.
// The result port cannot be stalled, so nothing in the pipeline waits.
// rst is synchronous: it clears the valid bits and loads the register reset values.
module masked_depth_to_point_projector_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [mdp_pkg::DEPTH_BITS-1:0] depth_sample,
  input  logic                           depth_not_finite,
  input  logic [7:0]                     mask_byte,
  input  logic [mdp_pkg::COORD_BITS-1:0] column,
  input  logic [mdp_pkg::COORD_BITS-1:0] row,
  input  logic                           frame_end_in,
  output logic                           done,
  output logic signed [mdp_pkg::XY_W-1:0] point_x,
  output logic signed [mdp_pkg::XY_W-1:0] point_y,
  output logic [mdp_pkg::DEPTH_BITS-1:0] point_z,
  output logic                           frame_end_out,
  input  logic                           cfg_write,
  input  logic [mdp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdp_pkg::CFG_W-1:0]      cfg_data
);
  import mdp_pkg::*;

  cfg_t     cfg;
  front_t   front;
  axis_in_t x_in;
  axis_in_t y_in;
  logic     accept;
  logic     x_valid;
  logic     y_valid;
  logic [XY_W-1:0] x_coord;
  logic [XY_W-1:0] y_coord;

  logic [DEPTH_BITS-1:0] depth_pipe [AXIS_STAGES];
  logic                  fe_pipe    [AXIS_STAGES];

  assign busy   = rst;
  assign accept = start && !busy;

  mdp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mdp_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .depth_sample     (depth_sample),
    .depth_not_finite (depth_not_finite),
    .mask_byte        (mask_byte),
    .column           (column),
    .row              (row),
    .frame_end_in     (frame_end_in),
    .cfg              (cfg),
    .front            (front),
    .x_in             (x_in),
    .y_in             (y_in)
  );

  mdp_axis u_axis_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front.valid),
    .ain       (x_in),
    .depth     (front.depth),
    .inv_focal (cfg.inv_focal_x),
    .out_valid (x_valid),
    .coord     (x_coord)
  );

  mdp_axis u_axis_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front.valid),
    .ain       (y_in),
    .depth     (front.depth),
    .inv_focal (cfg.inv_focal_y),
    .out_valid (y_valid),
    .coord     (y_coord)
  );

  // Depth and frame mark follow the projection stages.
  always_ff @(posedge clk) begin
    depth_pipe[0] <= front.depth;
    fe_pipe[0]    <= front.frame_end;
    for (int i = 1; i < AXIS_STAGES; i++) begin
      depth_pipe[i] <= depth_pipe[i-1];
      fe_pipe[i]    <= fe_pipe[i-1];
    end
  end

  assign done          = x_valid;
  assign point_x       = x_coord;
  assign point_y       = y_coord;
  assign point_z       = depth_pipe[AXIS_STAGES-1];
  assign frame_end_out = fe_pipe[AXIS_STAGES-1];

  // Every pixel transfer yields exactly one point.
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("pixel transfer without a point five cycles later");

  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 5))
    else $error("point without a pixel transfer five cycles earlier");

  // The two axis pipelines stay in lockstep.
  a_axes_aligned: assert property (@(posedge clk) disable iff (rst)
    x_valid == y_valid)
    else $error("x and y projection pipelines out of step");

  // Zero depth always projects to the origin.
  a_zero_depth_origin: assert property (@(posedge clk) disable iff (rst)
    (done && point_z == '0) |-> (point_x == '0 && point_y == '0))
    else $error("zero depth gave a nonzero point");

endmodule

[dv/mdp_point_checker.sv]
// Watches the pixel, point and register channels of the projector, predicts
// the point of every pixel transfer and compares it with the point the block
// delivers.
module mdp_point_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [mdp_pkg::DEPTH_BITS-1:0] depth_sample,
  input  logic                           depth_not_finite,
  input  logic [7:0]                     mask_byte,
  input  logic [mdp_pkg::COORD_BITS-1:0] column,
  input  logic [mdp_pkg::COORD_BITS-1:0] row,
  input  logic                           frame_end_in,
  input  logic                           done,
  input  logic [mdp_pkg::XY_W-1:0]       point_x,
  input  logic [mdp_pkg::XY_W-1:0]       point_y,
  input  logic [mdp_pkg::DEPTH_BITS-1:0] point_z,
  input  logic                           frame_end_out,
  input  logic                           cfg_write,
  input  logic [mdp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdp_pkg::CFG_W-1:0]      cfg_data,
  output int                             mismatches,
  output int                             outstanding,
  output int                             points_checked
);
  import mdp_pkg::*;

  localparam int MAX_REPORTS = 10;
  // Wide enough for the exact offset * depth * reciprocal product plus rounding.
  localparam int WIDE_W = MAG_W + DEPTH_BITS + INVF_W + 2;

  typedef struct {
    logic [XY_W-1:0]       x;
    logic [XY_W-1:0]       y;
    logic [DEPTH_BITS-1:0] z;
    logic                  fe;
  } point_t;

  cfg_t   regs;
  point_t expected_points[$];
  int     errs = 0;
  int     checked = 0;

  // One axis of the back-projection: offset from the principal point times
  // depth times the reciprocal focal length, rounded half away from zero to
  // Q.16 and saturated to the signed output range.
  function automatic logic [XY_W-1:0] back_project(input logic [COORD_BITS-1:0] pix,
      input logic [CENTER_W-1:0] center, input logic [DEPTH_BITS-1:0] d,
      input logic [INVF_W-1:0] invf);
    logic [PIX_W-1:0]  pos;
    logic [MAG_W-1:0]  mag;
    logic              neg;
    logic [WIDE_W-1:0] exact;
    logic [WIDE_W-1:0] scaled;
    pos = {pix, 4'b0000};
    neg = MAG_W'(pos) < MAG_W'(center);
    mag = neg ? MAG_W'(center) - MAG_W'(pos) : MAG_W'(pos) - MAG_W'(center);
    exact = WIDE_W'(mag) * WIDE_W'(d) * WIDE_W'(invf);
    scaled = (exact + (WIDE_W'(1) << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
    if (scaled > WIDE_W'(XY_MAX)) return neg ? XY_MIN : XY_MAX;
    return neg ? XY_W'(-scaled) : scaled[XY_W-1:0];
  endfunction

  // Masking wins over the clamp; a flagged or too deep sample takes max_range.
  function automatic point_t project_pixel(input cfg_t c);
    point_t                p;
    logic [DEPTH_BITS-1:0] d;
    if (mask_byte == 8'h00) d = '0;
    else if (depth_not_finite || depth_sample > c.max_range) d = c.max_range;
    else d = depth_sample;
    p.x  = back_project(column, c.principal_x, d, c.inv_focal_x);
    p.y  = back_project(row, c.principal_y, d, c.inv_focal_y);
    p.z  = d;
    p.fe = frame_end_in;
    return p;
  endfunction

  always @(posedge clk) begin : monitor
    point_t want;
    if (rst) begin
      regs <= '{PRINCIPAL_X_RST, PRINCIPAL_Y_RST, INV_FOCAL_X_RST, INV_FOCAL_Y_RST,
                MAX_RANGE_RST};
      expected_points.delete();
    end else begin
      // Register writes must only happen while no pixel is in flight; this checker does not enforce it.
      if (cfg_write) begin
        case (cfg_index)
          REG_PRINCIPAL_X: regs.principal_x <= cfg_data[CENTER_W-1:0];
          REG_PRINCIPAL_Y: regs.principal_y <= cfg_data[CENTER_W-1:0];
          REG_INV_FOCAL_X: regs.inv_focal_x <= cfg_data[INVF_W-1:0];
          REG_INV_FOCAL_Y: regs.inv_focal_y <= cfg_data[INVF_W-1:0];
          REG_MAX_RANGE:   regs.max_range   <= cfg_data[DEPTH_BITS-1:0];
          default: ;
        endcase
      end

      // Every pixel transfer yields exactly one point.
      if (start && !busy) expected_points.push_back(project_pixel(regs));

      // Each point transfer is matched against the oldest prediction.
      if (done) begin
        if (expected_points.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORTS)
            $display("Point with nothing pending: x=%0d y=%0d z=%0d fe=%0b",
                     $signed(point_x), $signed(point_y), point_z, frame_end_out);
        end else begin
          want = expected_points.pop_front();
          checked++;
          if (point_x !== want.x || point_y !== want.y || point_z !== want.z ||
              frame_end_out !== want.fe) begin
            errs++;
            if (errs <= MAX_REPORTS)
              $display("Point %0d: want x=%0d y=%0d z=%0d fe=%0b, got x=%0d y=%0d z=%0d fe=%0b",
                       checked, $signed(want.x), $signed(want.y), want.z, want.fe,
                       $signed(point_x), $signed(point_y), point_z, frame_end_out);
          end
        end
      end
    end
    mismatches     <= errs;
    outstanding    <= expected_points.size();
    points_checked <= checked;
  end

endmodule

[dv/masked_depth_to_point_projector_top_test.sv]
module masked_depth_to_point_projector_top_test;
  import mdp_pkg::*;

  localparam int IDLE_LIMIT       = 500;
  localparam int RANDOM_PHASES    = 6;
  localparam int PIXELS_PER_PHASE = 155;
  localparam int SETTLE_CYCLES    = 8;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [DEPTH_BITS-1:0]  depth_sample = '0;
  logic                   depth_not_finite = 1'b0;
  logic [7:0]             mask_byte = '0;
  logic [COORD_BITS-1:0]  column = '0;
  logic [COORD_BITS-1:0]  row = '0;
  logic                   frame_end_in = 1'b0;
  logic                   done;
  logic signed [XY_W-1:0] point_x;
  logic signed [XY_W-1:0] point_y;
  logic [DEPTH_BITS-1:0]  point_z;
  logic                   frame_end_out;
  logic                   cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  int   mismatches;
  int   outstanding;
  int   points_checked;
  int   pixels_sent = 0;
  int   masked_sent = 0;
  int   settings_applied = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;
  cfg_t setting;

  masked_depth_to_point_projector_top dut (.*);

  mdp_point_checker point_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ends the run when neither a pixel nor a point has moved for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("masked_depth_to_point_projector_top_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one pixel and returns after its transfer. The sender works in
  // bursts; between bursts start may drop for a random number of cycles.
  task automatic send_pixel(input logic [DEPTH_BITS-1:0] d, input logic nf,
      input logic [7:0] m, input logic [COORD_BITS-1:0] u,
      input logic [COORD_BITS-1:0] v, input logic fe);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start            <= 1'b1;
    depth_sample     <= d;
    depth_not_finite <= nf;
    mask_byte        <= m;
    column           <= u;
    row              <= v;
    frame_end_in     <= fe;
    do @(posedge clk); while (busy);
    pixels_sent++;
    if (m == 8'h00) masked_sent++;
  endtask

  // Holds the sender off until every predicted point has arrived.
  task automatic drain_points();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Loads all five registers; only called with the pipeline empty.
  task automatic apply_setting(input cfg_t s);
    write_reg(REG_PRINCIPAL_X, CFG_W'(s.principal_x));
    write_reg(REG_PRINCIPAL_Y, CFG_W'(s.principal_y));
    write_reg(REG_INV_FOCAL_X, CFG_W'(s.inv_focal_x));
    write_reg(REG_INV_FOCAL_Y, CFG_W'(s.inv_focal_y));
    write_reg(REG_MAX_RANGE, CFG_W'(s.max_range));
    cfg_write <= 1'b0;
    setting = s;
    settings_applied++;
  endtask

  // Reciprocal focal lengths are camera-like half the time, otherwise anything.
  function automatic logic [INVF_W-1:0] random_inv_focal();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return INVF_W'($urandom);
      default: return INVF_W'($urandom_range(8000, 200000));
    endcase
  endfunction

  function automatic cfg_t random_setting();
    cfg_t s;
    s.principal_x = CENTER_W'($urandom);
    s.principal_y = CENTER_W'($urandom);
    s.inv_focal_x = random_inv_focal();
    s.inv_focal_y = random_inv_focal();
    s.max_range   = ($urandom_range(0, 1) == 0) ? DEPTH_BITS'($urandom_range(65536, 1310720))
                                                : DEPTH_BITS'($urandom);
    return s;
  endfunction

  function automatic logic [COORD_BITS-1:0] random_coord();
    if ($urandom_range(0, 9) == 0)
      return ($urandom_range(0, 1) == 0) ? {COORD_BITS{1'b0}} : {COORD_BITS{1'b1}};
    return COORD_BITS'($urandom);
  endfunction

  // Random pixels with depths bunched around zero, full scale and the clamp.
  task automatic run_random_phase(input int n);
    logic [DEPTH_BITS-1:0] d;
    logic [7:0]            m;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       d = '0;
        1:       d = '1;
        2, 3:    d = setting.max_range + DEPTH_BITS'($urandom_range(0, 2)) - DEPTH_BITS'(1);
        4, 5, 6: d = DEPTH_BITS'($urandom_range(0, 32'(setting.max_range)));
        default: d = DEPTH_BITS'($urandom);
      endcase
      m = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      send_pixel(d, $urandom_range(0, 6) == 0, m, random_coord(), random_coord(),
                 $urandom_range(0, 15) == 0);
      if (i == n / 2 && $urandom_range(0, 1) == 0) drain_points();
    end
    drain_points();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    setting = '{PRINCIPAL_X_RST, PRINCIPAL_Y_RST, INV_FOCAL_X_RST, INV_FOCAL_Y_RST,
                MAX_RANGE_RST};

    // Reset setting: zero depth, clamping, the principal point, the not-finite
    // flag and masked pixels.
    send_pixel(24'h000000, 1'b0, 8'h01, 12'h000, 12'h000, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0, 8'hFF, 12'hFFF, 12'hFFF, 1'b1);
    send_pixel(24'd655360, 1'b0, 8'h01, 12'd320, 12'd240, 1'b0);
    send_pixel(24'd655361, 1'b0, 8'h02, 12'd321, 12'd239, 1'b0);
    send_pixel(24'h123456, 1'b1, 8'h04, 12'h000, 12'hFFF, 1'b0);
    send_pixel(24'hFFFFFF, 1'b1, 8'h00, 12'hFFF, 12'h000, 1'b1);
    send_pixel(24'd100, 1'b0, 8'h00, 12'h123, 12'h456, 1'b0);
    send_pixel(24'h0ABCDE, 1'b0, 8'h55, 12'hAAA, 12'h555, 1'b0);
    drain_points();

    // Products exactly halfway and one step either side: x above and y below the principal point.
    apply_setting('{16'd15, 16'd17, 24'd16, 24'd16, 24'hFFFFFF});
    send_pixel(24'h800000, 1'b0, 8'h01, 12'd1, 12'd1, 1'b0);
    send_pixel(24'h7FFFFF, 1'b0, 8'h01, 12'd1, 12'd1, 1'b0);
    send_pixel(24'h800001, 1'b0, 8'h01, 12'd1, 12'd1, 1'b1);
    drain_points();

    // Full-scale registers drive x into positive and y into negative saturation.
    apply_setting('{16'h0000, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF});
    send_pixel(24'hFFFFFF, 1'b0, 8'h01, 12'hFFF, 12'h000, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0, 8'h10, 12'h000, 12'hFFF, 1'b0);
    send_pixel(24'h000000, 1'b1, 8'h80, 12'h800, 12'h7FF, 1'b0);
    send_pixel(24'hFFFFFF, 1'b1, 8'h00, 12'hFFF, 12'hFFF, 1'b1);
    send_pixel(24'h000001, 1'b0, 8'hFE, 12'hFFF, 12'hFFF, 1'b0);
    drain_points();

    // All registers zero: every unmasked depth clamps to zero.
    apply_setting('{16'h0000, 16'h0000, 24'h000000, 24'h000000, 24'h000000});
    send_pixel(24'd5, 1'b0, 8'h01, 12'hFFF, 12'h001, 1'b0);
    send_pixel(24'h000000, 1'b1, 8'h20, 12'h001, 12'hFFF, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0, 8'h00, 12'h400, 12'h200, 1'b1);
    drain_points();

    // Random phases, the first back at the reset setting.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0)
        apply_setting('{PRINCIPAL_X_RST, PRINCIPAL_Y_RST, INV_FOCAL_X_RST, INV_FOCAL_Y_RST,
                        MAX_RANGE_RST});
      else
        apply_setting(random_setting());
      run_random_phase(PIXELS_PER_PHASE);
    end

    $display("Sent %0d pixels (%0d masked) under %0d register settings; %0d points checked.",
             pixels_sent, masked_sent, settings_applied, points_checked);
    $display("Covered clamping, not-finite depths, rounding ties and x/y saturation.");
    if (mismatches == 0 && outstanding == 0)
      $display("masked_depth_to_point_projector_top_test passed");
    else
      $display("masked_depth_to_point_projector_top_test failed");
    $finish;
  end

endmodule
